### rtl/core/rfma_pkg.sv
package rfma_pkg;

	// operation codes carried in tuser
	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_FOLD  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam int CNT_W  = 32;   // current count width
	localparam int TOT_W  = 48;   // total width, 16 fraction bits
	localparam int SUM_W  = 59;   // total plus addend before saturation
	localparam int Q_W    = 16;   // cos/sin width, Q1.14
	localparam int PT_W   = 28;   // sample point, Q.15, maps up to 1024 wide
	localparam int MUL_W  = 33;   // shared multiplier operand width
	localparam int PROD_W = 66;   // shared multiplier product width
	localparam int BIL_W  = 64;   // bilinear sum, Q.30
	localparam int SMP_W  = 50;   // sampled vector, Q.16
	localparam int ACC_W  = 72;   // rotation accumulator, Q.30
	localparam int CUR_DW = 2 * CNT_W;
	localparam int TOT_DW = 2 * TOT_W;

	localparam logic signed [Q_W-1:0] Q_ONE = 16'sd16384;
	localparam logic signed [SUM_W-1:0] TOT_MAX = 59'sd140737488355327;
	localparam logic signed [SUM_W-1:0] TOT_MIN = -59'sd140737488355328;

	// one input item
	typedef struct packed {
		op_t                     op;
		logic [7:0]              cx;
		logic [7:0]              cz;
		logic                    ew;
		logic                    neg;
		logic                    rot;
		logic signed [Q_W-1:0]   cos;
		logic signed [Q_W-1:0]   sin;
	} item_t;

	// one result item
	typedef struct packed {
		logic                    valid;
		logic signed [TOT_W-1:0] ew;
		logic signed [TOT_W-1:0] ns;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLR_ALL,
		ST_IDLE,
		ST_EV_WR,
		ST_RD_OUT,
		ST_TCLR,
		ST_CCLR,
		ST_FS_RD,
		ST_FS_WR,
		ST_R_INIT1,
		ST_R_INIT2,
		ST_R_CELL,
		ST_R_RD,
		ST_R_MA,
		ST_R_MB,
		ST_R_MC,
		ST_R_RND,
		ST_R_PA,
		ST_R_PB,
		ST_R_TRD,
		ST_R_TWR
	} state_t;

	function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [Q_W-1:0] v);
		logic signed [Q_W-1:0] r;
		r = v;
		if (v > Q_ONE) r = Q_ONE;
		if (v < -Q_ONE) r = -Q_ONE;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] step_count(input logic [CNT_W-1:0] c,
			input logic neg);
		logic [CNT_W-1:0] r;
		r = c;
		if (!neg) begin
			if (c != 32'h7FFF_FFFF) r = c + 32'd1;
		end else begin
			if (c != 32'h8000_0000) r = c - 32'd1;
		end
		return r;
	endfunction

	function automatic logic [TOT_W-1:0] sat_tot(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (v > TOT_MAX) r = TOT_MAX;
		if (v < TOT_MIN) r = TOT_MIN;
		return r[TOT_W-1:0];
	endfunction

endpackage

### rtl/core/rfma_mul.sv
module rfma_mul (
	input  logic                               clk,
	input  logic signed [rfma_pkg::MUL_W-1:0]  a,
	input  logic signed [rfma_pkg::MUL_W-1:0]  b,
	output logic signed [rfma_pkg::PROD_W-1:0] p
);
	import rfma_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	// registered signed product
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

### rtl/core/rfma_core.sv
module rfma_core #(
	parameter int MAP_WIDTH = 256,
	parameter int MAP_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rfma_pkg::item_t req,
	output logic            idle,
	output rfma_pkg::res_t  res
);
	import rfma_pkg::*;

	localparam int N  = MAP_WIDTH * MAP_DEPTH;
	localparam int AW = $clog2(N);
	localparam int XW = $clog2(MAP_WIDTH);
	localparam int ZW = $clog2(MAP_DEPTH);
	localparam logic [AW-1:0] WA   = AW'(MAP_WIDTH);
	localparam logic [AW-1:0] LAST = AW'(N - 1);
	localparam logic signed [PT_W-1:0] WM1  = PT_W'(MAP_WIDTH - 1);
	localparam logic signed [PT_W-1:0] DM1  = PT_W'(MAP_DEPTH - 1);
	localparam logic signed [PT_W-1:0] XMAX = PT_W'((MAP_WIDTH - 2) * 32768);
	localparam logic signed [PT_W-1:0] ZMAX = PT_W'((MAP_DEPTH - 2) * 32768);
	localparam logic signed [PT_W-1:0] XC0  = PT_W'((MAP_WIDTH - 1) * 16384);
	localparam logic signed [PT_W-1:0] ZC0  = PT_W'((MAP_DEPTH - 1) * 16384);

	// map memories: current counts {ns, ew} and totals {ns, ew}
	logic [CUR_DW-1:0] cur_mem [N];
	logic [TOT_DW-1:0] tot_mem [N];
	logic [CUR_DW-1:0] rd_c_q;
	logic [TOT_DW-1:0] rd_t_q;

	logic              we_c, re_c, we_t, re_t;
	logic [AW-1:0]     wa_c, ra_c, wa_t, ra_t;
	logic [CUR_DW-1:0] wd_c;
	logic [TOT_DW-1:0] wd_t;

	state_t            state_q, state_d;
	item_t             item_q;
	logic [AW-1:0]     idx_q;
	logic              rot_q;
	logic signed [Q_W-1:0] cos_q, sin_q;

	logic signed [PT_W-1:0] rx_q, rz_q, px_q, pz_q;
	logic [XW-1:0]     xc_q;
	logic [AW-1:0]     i0_q;
	logic [14:0]       fx_q, fz_q;
	logic [1:0]        k_q;
	logic [2:0]        j_q;
	logic [31:0]       w_q;
	logic signed [BIL_W-1:0] sew_q, sns_q;
	logic signed [SMP_W-1:0] ew_q, ns_q;
	logic signed [ACC_W-1:0] racc_ew_q, racc_ns_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic              in_map, last_idx, adv_idx, step_cell, skip;
	logic [AW-1:0]     a_in, nb_off;
	logic [15:0]       wx, wz;
	logic signed [PT_W-1:0] rx_i1, rz_i1, rx_i2, rz_i2;
	logic signed [SMP_W-1:0] src;
	logic signed [MUL_W-1:0] coef;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] rnd_ew, rnd_ns;
	logic signed [SUM_W-1:0] fs_ew, fs_ns, rt_ew, rt_ns;

	rfma_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// memory ports
	always_ff @(posedge clk) begin
		if (we_c) cur_mem[wa_c] <= wd_c;
		if (re_c) rd_c_q <= cur_mem[ra_c];
	end

	always_ff @(posedge clk) begin
		if (we_t) tot_mem[wa_t] <= wd_t;
		if (re_t) rd_t_q <= tot_mem[ra_t];
	end

	// address and point helpers
	assign in_map   = (int'(req.cx) < MAP_WIDTH) && (int'(req.cz) < MAP_DEPTH);
	assign a_in     = AW'(req.cz) * WA + AW'(req.cx);
	assign last_idx = (idx_q == LAST);
	assign skip     = (px_q < 0) || (px_q > XMAX) || (pz_q < 0) || (pz_q > ZMAX);
	assign nb_off   = (k_q[1] ? WA : '0) + (k_q[0] ? AW'(1) : '0);
	assign wx       = k_q[0] ? {1'b0, fx_q} : (16'd32768 - {1'b0, fx_q});
	assign wz       = k_q[1] ? {1'b0, fz_q} : (16'd32768 - {1'b0, fz_q});
	assign rx_i1    = XC0 - PT_W'(cos_q) * WM1;
	assign rz_i1    = ZC0 - PT_W'(sin_q) * WM1;
	assign rx_i2    = rx_q + PT_W'(sin_q) * DM1;
	assign rz_i2    = rz_q - PT_W'(cos_q) * DM1;

	// rotation term: j[2] picks the result, j[1] the cross term, j[0] the high part
	assign src    = (j_q[2] ^ j_q[1]) ? ns_q : ew_q;
	assign coef   = j_q[1] ? (j_q[2] ? -MUL_W'(sin_q) : MUL_W'(sin_q)) : MUL_W'(cos_q);
	assign term   = ACC_W'(mul_p) <<< (j_q[0] ? 24 : 0);
	assign rnd_ew = (racc_ew_q + ACC_W'(8192)) >>> 14;
	assign rnd_ns = (racc_ns_q + ACC_W'(8192)) >>> 14;

	// saturating total updates
	assign fs_ew = SUM_W'($signed(rd_t_q[TOT_W-1:0]))
		+ SUM_W'($signed({rd_c_q[CNT_W-1:0], 16'h0}));
	assign fs_ns = SUM_W'($signed(rd_t_q[TOT_DW-1:TOT_W]))
		+ SUM_W'($signed({rd_c_q[CUR_DW-1:CNT_W], 16'h0}));
	assign rt_ew = SUM_W'($signed(rd_t_q[TOT_W-1:0])) + SUM_W'(rnd_ew);
	assign rt_ns = SUM_W'($signed(rd_t_q[TOT_DW-1:TOT_W])) + SUM_W'(rnd_ns);

	assign idle = (state_q == ST_IDLE);

	// next state, memory controls and result
	always_comb begin
		state_d   = state_q;
		we_c      = 1'b0;
		re_c      = 1'b0;
		wa_c      = idx_q;
		ra_c      = idx_q;
		wd_c      = '0;
		we_t      = 1'b0;
		re_t      = 1'b0;
		wa_t      = idx_q;
		ra_t      = idx_q;
		wd_t      = '0;
		mul_a     = '0;
		mul_b     = '0;
		res       = '0;
		adv_idx   = 1'b0;
		step_cell = 1'b0;
		unique case (state_q)
			ST_CLR_ALL: begin
				we_c    = 1'b1;
				we_t    = 1'b1;
				adv_idx = 1'b1;
				if (last_idx) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (req.op)
						OP_EVENT: begin
							if (in_map) begin
								re_c    = 1'b1;
								ra_c    = a_in;
								state_d = ST_EV_WR;
							end else begin
								res.valid = 1'b1;
							end
						end
						OP_READ: begin
							if (in_map) begin
								re_t    = 1'b1;
								ra_t    = a_in;
								state_d = ST_RD_OUT;
							end else begin
								res.valid = 1'b1;
							end
						end
						OP_FOLD:  state_d = rot_q ? ST_R_INIT1 : ST_FS_RD;
						OP_CLEAR: state_d = ST_TCLR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_EV_WR: begin
				we_c = 1'b1;
				if (item_q.ew) begin
					wd_c = {rd_c_q[CUR_DW-1:CNT_W], step_count(rd_c_q[CNT_W-1:0], item_q.neg)};
				end else begin
					wd_c = {step_count(rd_c_q[CUR_DW-1:CNT_W], item_q.neg), rd_c_q[CNT_W-1:0]};
				end
				res.valid = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_RD_OUT: begin
				res.valid = 1'b1;
				res.ew    = rd_t_q[TOT_W-1:0];
				res.ns    = rd_t_q[TOT_DW-1:TOT_W];
				state_d   = ST_IDLE;
			end
			ST_TCLR: begin
				we_t    = 1'b1;
				adv_idx = 1'b1;
				if (last_idx) begin
					res.valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_CCLR: begin
				we_c    = 1'b1;
				adv_idx = 1'b1;
				if (last_idx) begin
					res.valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_FS_RD: begin
				re_c    = 1'b1;
				re_t    = 1'b1;
				state_d = ST_FS_WR;
			end
			ST_FS_WR: begin
				we_t    = 1'b1;
				wd_t    = {sat_tot(fs_ns), sat_tot(fs_ew)};
				adv_idx = 1'b1;
				state_d = last_idx ? ST_CCLR : ST_FS_RD;
			end
			ST_R_INIT1: state_d = ST_R_INIT2;
			ST_R_INIT2: state_d = ST_R_CELL;
			ST_R_CELL: begin
				if (skip) begin
					adv_idx   = 1'b1;
					step_cell = 1'b1;
					if (last_idx) state_d = ST_CCLR;
				end else begin
					state_d = ST_R_RD;
				end
			end
			ST_R_RD: begin
				re_c    = 1'b1;
				ra_c    = i0_q + nb_off;
				state_d = ST_R_MA;
			end
			ST_R_MA: begin
				mul_a   = MUL_W'($signed(rd_c_q[CNT_W-1:0]));
				mul_b   = MUL_W'(w_q);
				state_d = ST_R_MB;
			end
			ST_R_MB: begin
				mul_a   = MUL_W'($signed(rd_c_q[CUR_DW-1:CNT_W]));
				mul_b   = MUL_W'(w_q);
				state_d = ST_R_MC;
			end
			ST_R_MC:  state_d = (k_q == 2'd3) ? ST_R_RND : ST_R_RD;
			ST_R_RND: state_d = ST_R_PA;
			ST_R_PA: begin
				mul_a   = coef;
				mul_b   = j_q[0] ? MUL_W'(src >>> 24) : MUL_W'({1'b0, src[23:0]});
				state_d = ST_R_PB;
			end
			ST_R_PB:  state_d = (j_q == 3'd7) ? ST_R_TRD : ST_R_PA;
			ST_R_TRD: begin
				re_t    = 1'b1;
				state_d = ST_R_TWR;
			end
			ST_R_TWR: begin
				we_t      = 1'b1;
				wd_t      = {sat_tot(rt_ns), sat_tot(rt_ew)};
				adv_idx   = 1'b1;
				step_cell = 1'b1;
				state_d   = last_idx ? ST_CCLR : ST_R_CELL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_ALL;
			idx_q   <= '0;
			rot_q   <= 1'b0;
			cos_q   <= Q_ONE;
			sin_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				idx_q <= (req.op == OP_EVENT) ? a_in : '0;
			end else if (adv_idx) begin
				idx_q <= last_idx ? '0 : idx_q + AW'(1);
			end
			// the next map angle takes effect once the fold has walked the map
			if (state_d == ST_CCLR && state_q != ST_CCLR) begin
				rot_q <= item_q.rot;
				cos_q <= clamp_q(item_q.cos);
				sin_q <= clamp_q(item_q.sin);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) item_q <= req;
		case (state_q)
			ST_R_INIT1: begin
				rx_q <= rx_i1;
				rz_q <= rz_i1;
			end
			ST_R_INIT2: begin
				rx_q <= rx_i2;
				rz_q <= rz_i2;
				px_q <= rx_i2;
				pz_q <= rz_i2;
				xc_q <= '0;
			end
			ST_R_CELL: begin
				i0_q  <= AW'(pz_q[ZW+14:15]) * WA + AW'(px_q[XW+14:15]);
				fx_q  <= px_q[14:0];
				fz_q  <= pz_q[14:0];
				k_q   <= '0;
				sew_q <= '0;
				sns_q <= '0;
			end
			ST_R_RD: w_q <= wx * wz;
			ST_R_MB: sew_q <= sew_q + BIL_W'(mul_p);
			ST_R_MC: begin
				sns_q <= sns_q + BIL_W'(mul_p);
				k_q   <= k_q + 2'd1;
			end
			ST_R_RND: begin
				ew_q      <= SMP_W'((sew_q + BIL_W'(8192)) >>> 14);
				ns_q      <= SMP_W'((sns_q + BIL_W'(8192)) >>> 14);
				j_q       <= '0;
				racc_ew_q <= '0;
				racc_ns_q <= '0;
			end
			ST_R_PB: begin
				if (j_q[2]) racc_ns_q <= racc_ns_q + term;
				else racc_ew_q <= racc_ew_q + term;
				j_q <= j_q + 3'd1;
			end
			default: ;
		endcase
		// walk the sample point one cell along x, wrapping to the next row
		if (step_cell) begin
			if (xc_q == XW'(MAP_WIDTH - 1)) begin
				xc_q <= '0;
				rx_q <= rx_q - (PT_W'(sin_q) <<< 1);
				rz_q <= rz_q + (PT_W'(cos_q) <<< 1);
				px_q <= rx_q - (PT_W'(sin_q) <<< 1);
				pz_q <= rz_q + (PT_W'(cos_q) <<< 1);
			end else begin
				xc_q <= xc_q + XW'(1);
				px_q <= px_q + (PT_W'(cos_q) <<< 1);
				pz_q <= pz_q + (PT_W'(sin_q) <<< 1);
			end
		end
	end

	// checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("item started while core busy");

	a_cur_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(we_c || re_c) |-> (wa_c <= LAST && ra_c <= LAST))
		else $error("current map address out of range");

	a_tot_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(we_t || re_t) |-> (wa_t <= LAST && ra_t <= LAST))
		else $error("total map address out of range");

	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_IDLE || state_q == ST_EV_WR
			|| state_q == ST_RD_OUT || state_q == ST_CCLR || state_q == ST_TCLR))
		else $error("result outside a finishing state");

endmodule

### rtl/core/rotated_flux_map_accumulator.sv
// channel | dir | signals                     | payload
// s       | in  | s_tvalid s_tready s_tuser   | tuser: operation; tdata: item fields
// m       | out | m_tvalid m_tready m_tdata   | tdata: total_east_west, total_north_south
//
// event and read each access one map cell and give the result; clear walks the total map;
// an unrotated fold reads and writes every total cell, then clears the current map
// a rotated fold sets up the sample point, then walks every cell, skipping out-of-range ones,
// then clears the current map and gives the result; one map memory port bounds each step
// after reset the core clears both map memories before taking an item
// a new item is taken once the core is idle and the result register is free or being emptied
module rotated_flux_map_accumulator #(
	parameter int MAP_WIDTH = 256,
	parameter int MAP_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// column_x, column_z, is_east_west, step_negative, new_rotated, new_cos, new_sin
	input  logic [55:0] s_tdata,
	// operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// total_east_west, total_north_south
	output logic [95:0] m_tdata
);
	import rfma_pkg::*;

	item_t       req;
	res_t        res;
	logic        core_idle, start;
	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;

	// unpack the input transfer
	always_comb begin
		req.op  = op_t'(s_tuser);
		req.cx  = s_tdata[7:0];
		req.cz  = s_tdata[15:8];
		req.ew  = s_tdata[16];
		req.neg = s_tdata[17];
		req.rot = s_tdata[18];
		req.cos = s_tdata[34:19];
		req.sin = s_tdata[50:35];
	end

	assign s_tready = core_idle && (!m_tvalid_q || m_tready);
	assign start    = s_tvalid && s_tready;

	rfma_core #(
		.MAP_WIDTH (MAP_WIDTH),
		.MAP_DEPTH (MAP_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.idle   (core_idle),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (res.valid) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) m_tdata_q <= {res.ns, res.ew};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import rfma_pkg::*;

	localparam int MAP_W = 256;
	localparam int MAP_D = 256;
	localparam int CELLS = MAP_W * MAP_D;
	localparam longint TOTAL_HI = 64'sd140737488355327;
	localparam longint TOTAL_LO = -64'sd140737488355328;
	localparam int STALL_LIMIT = 12000000;

	typedef struct {
		longint ew;
		longint ns;
	} cell_total_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	// predictor state
	longint cur_ew [CELLS];
	longint cur_ns [CELLS];
	longint tot_ew [CELLS];
	longint tot_ns [CELLS];
	longint map_cos;
	longint map_sin;
	bit     map_rot;

	cell_total_t pending_totals[$];
	int  errors;
	int  idle_cycles;
	bit  steady;

	rotated_flux_map_accumulator #(.MAP_WIDTH(MAP_W), .MAP_DEPTH(MAP_D)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	function automatic longint sat_total(input longint v);
		if (v > TOTAL_HI) return TOTAL_HI;
		if (v < TOTAL_LO) return TOTAL_LO;
		return v;
	endfunction

	// add half then floor
	function automatic longint round_q(input longint v, input int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp_angle(input logic signed [15:0] v);
		longint r;
		r = v;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	// bilinear resample of the current map into the total map
	task automatic fold_rotated_maps();
		longint dx2, dz2, x0, z0, fx, fz, w00, w10, w01, w11, sew, sns, ew, ns;
		int i0, dst;
		for (int z = 0; z < MAP_D; z++) begin
			for (int x = 0; x < MAP_W; x++) begin
				dx2 = 2 * x - (MAP_W - 1);
				dz2 = 2 * z - (MAP_D - 1);
				x0 = (longint'(MAP_W - 1) <<< 14) + map_cos * dx2 - map_sin * dz2;
				z0 = (longint'(MAP_D - 1) <<< 14) + map_sin * dx2 + map_cos * dz2;
				if (x0 < 0 || x0 > (longint'(MAP_W - 2) <<< 15) ||
						z0 < 0 || z0 > (longint'(MAP_D - 2) <<< 15))
					continue;
				fx = x0 & 32767;
				fz = z0 & 32767;
				i0 = int'((z0 >>> 15) * MAP_W + (x0 >>> 15));
				w00 = (32768 - fx) * (32768 - fz);
				w10 = fx * (32768 - fz);
				w01 = (32768 - fx) * fz;
				w11 = fx * fz;
				sew = w00 * cur_ew[i0] + w10 * cur_ew[i0 + 1] + w01 * cur_ew[i0 + MAP_W]
					+ w11 * cur_ew[i0 + MAP_W + 1];
				sns = w00 * cur_ns[i0] + w10 * cur_ns[i0 + 1] + w01 * cur_ns[i0 + MAP_W]
					+ w11 * cur_ns[i0 + MAP_W + 1];
				ew = round_q(sew, 14);
				ns = round_q(sns, 14);
				dst = z * MAP_W + x;
				tot_ew[dst] = sat_total(tot_ew[dst] + round_q(map_cos * ew + map_sin * ns, 14));
				tot_ns[dst] = sat_total(tot_ns[dst] + round_q(map_cos * ns - map_sin * ew, 14));
			end
		end
	endtask

	// work out the result of one accepted item and update the maps
	task automatic update_flux_maps(input item_t it);
		cell_total_t res;
		int idx;
		longint c;
		res.ew = 0;
		res.ns = 0;
		idx = int'(it.cx) + int'(it.cz) * MAP_W;
		case (it.op)
			OP_EVENT: begin
				c = it.ew ? cur_ew[idx] : cur_ns[idx];
				c = it.neg ? c - 1 : c + 1;
				if (c > 64'sd2147483647) c = 64'sd2147483647;
				if (c < -64'sd2147483648) c = -64'sd2147483648;
				if (it.ew) cur_ew[idx] = c;
				else cur_ns[idx] = c;
			end
			OP_FOLD: begin
				if (map_rot) begin
					fold_rotated_maps();
				end else begin
					for (int i = 0; i < CELLS; i++) begin
						tot_ew[i] = sat_total(tot_ew[i] + cur_ew[i] * 65536);
						tot_ns[i] = sat_total(tot_ns[i] + cur_ns[i] * 65536);
					end
				end
				for (int i = 0; i < CELLS; i++) begin
					cur_ew[i] = 0;
					cur_ns[i] = 0;
				end
				map_rot = it.rot;
				map_cos = clamp_angle(it.cos);
				map_sin = clamp_angle(it.sin);
			end
			OP_READ: begin
				res.ew = tot_ew[idx];
				res.ns = tot_ns[idx];
			end
			default: begin
				for (int i = 0; i < CELLS; i++) begin
					tot_ew[i] = 0;
					tot_ns[i] = 0;
				end
			end
		endcase
		pending_totals.push_back(res);
	endtask

	// present one item, hold it until the transfer, then predict
	task automatic send_item(input op_t op, input logic [7:0] cx, input logic [7:0] cz,
			input logic ew, input logic neg, input logic rot,
			input logic signed [15:0] cosv, input logic signed [15:0] sinv);
		item_t it;
		it.op = op; it.cx = cx; it.cz = cz; it.ew = ew; it.neg = neg;
		it.rot = rot; it.cos = cosv; it.sin = sinv;
		if (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, sinv, cosv, rot, neg, ew, cz, cx};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		update_flux_maps(it);
	endtask

	task automatic send_event(input logic [7:0] cx, input logic [7:0] cz,
			input logic ew, input logic neg);
		send_item(OP_EVENT, cx, cz, ew, neg, 1'b0, 16'sd0, 16'sd0);
	endtask

	task automatic send_read(input logic [7:0] cx, input logic [7:0] cz);
		send_item(OP_READ, cx, cz, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0);
	endtask

	// hold off until every expected result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_totals.size() != 0) @(posedge clk);
	endtask

	// events clustered near the center so folds and rotation see them
	task automatic cluster_events(input int n);
		for (int i = 0; i < n; i++)
			send_event(8'($urandom_range(96, 159)), 8'($urandom_range(96, 159)),
				1'($urandom_range(1)), $urandom_range(99) < 30);
	endtask

	task automatic cluster_reads(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) send_read(8'($urandom), 8'($urandom));
			else send_read(8'($urandom_range(80, 175)), 8'($urandom_range(80, 175)));
		end
	endtask

	task automatic test_reset_state();
		send_read(8'd0, 8'd0);
		send_read(8'd255, 8'd255);
		send_read(8'd0, 8'd255);
	endtask

	task automatic test_corner_events();
		send_event(8'd0, 8'd0, 1'b1, 1'b0);
		send_event(8'd0, 8'd0, 1'b0, 1'b1);
		send_event(8'd255, 8'd255, 1'b1, 1'b1);
		send_event(8'd255, 8'd255, 1'b0, 1'b0);
		send_event(8'd255, 8'd0, 1'b1, 1'b0);
		send_event(8'd0, 8'd255, 1'b0, 1'b1);
		send_event(8'd128, 8'd128, 1'b1, 1'b0);
		send_event(8'd128, 8'd128, 1'b1, 1'b0);
		send_event(8'd128, 8'd128, 1'b0, 1'b1);
		cluster_events(350);
	endtask

	// straight fold; next map gets out-of-range angle values that clamp
	task automatic test_straight_fold();
		send_item(OP_FOLD, 8'($urandom), 8'($urandom), 1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'sh8000);
		send_read(8'd0, 8'd0);
		send_read(8'd255, 8'd255);
		send_read(8'd128, 8'd128);
		cluster_reads(200);
	endtask

	// second map accumulated with no idling on either side
	task automatic test_steady_events();
		steady = 1'b1;
		cluster_events(400);
		steady = 1'b0;
	endtask

	// rotated fold, then back to an unrotated map
	task automatic test_rotated_fold();
		wait_drained();
		send_item(OP_FOLD, 8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b0, 16'sh8000, 16'sh7FFF);
		cluster_reads(450);
	endtask

	task automatic test_clear_total();
		send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom_range(1)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
		send_read(8'd128, 8'd128);
		send_read(8'd0, 8'd0);
	endtask

	// events and reads mixed, anywhere on the map
	task automatic test_random_mix();
		for (int i = 0; i < 450; i++) begin
			if ($urandom_range(1)) send_event(8'($urandom), 8'($urandom),
				1'($urandom_range(1)), 1'($urandom_range(1)));
			else send_read(8'($urandom), 8'($urandom));
		end
	endtask

	// result checker, sampled mid-cycle before the transfer edge
	always @(negedge clk) begin
		cell_total_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_totals.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				errors++;
			end else begin
				exp_res = pending_totals.pop_front();
				if (m_tdata[47:0] !== exp_res.ew[47:0]) begin
					$error("total_east_west expected %h got %h", exp_res.ew[47:0],
						m_tdata[47:0]);
					errors++;
				end
				if (m_tdata[95:48] !== exp_res.ns[47:0]) begin
					$error("total_north_south expected %h got %h", exp_res.ns[47:0],
						m_tdata[95:48]);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 30);
	end

	// watchdog on cycles with no transfer on either side
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		errors = 0;
		idle_cycles = 0;
		steady = 1'b0;
		map_cos = 16384;
		map_sin = 0;
		map_rot = 1'b0;
		for (int i = 0; i < CELLS; i++) begin
			cur_ew[i] = 0; cur_ns[i] = 0; tot_ew[i] = 0; tot_ns[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_corner_events();
		test_straight_fold();
		test_steady_events();
		test_rotated_fold();
		test_clear_total();
		test_random_mix();

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
